/* rtl/jsm_pkg.sv */
// Shared types, constants and character helpers of the stream minifier.
package jsm_pkg;

	localparam int LOOKAHEAD_DEPTH = 4;
	localparam int LA_SLOTS = (LOOKAHEAD_DEPTH > 3) ? LOOKAHEAD_DEPTH : 3;
	localparam int LA_CW = $clog2(LA_SLOTS + 1);
	localparam int MAX_RESULTS = 8;
	localparam int RI_W = $clog2(MAX_RESULTS);
	localparam int RN_W = $clog2(MAX_RESULTS + 1);

	// 9-bit internal character; this value marks end of file
	localparam logic [8:0] EOFV = 9'h100;

	localparam logic [1:0] CMD_EMIT = 2'd0;
	localparam logic [1:0] CMD_DEL_A = 2'd1;
	localparam logic [1:0] CMD_DEL_B = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_COMMENT = 3'd1;
	localparam logic [2:0] ERR_STRING = 3'd2;
	localparam logic [2:0] ERR_REGEX = 3'd3;
	localparam logic [2:0] ERR_COND = 3'd4;

	localparam logic [1:0] CFG_STRIP_COMMENTS = 2'd0;
	localparam logic [1:0] CFG_STRIP_DEBUG = 2'd1;
	localparam logic [1:0] CFG_MINIMIZE_ON = 2'd2;

	typedef struct packed {
		logic       end_of_input;
		logic [7:0] in_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic [2:0] error_code;
		logic       last;
		logic       stream_done;
	} out_item_t;

	// queued item: filtered character (EOFV for the end mark) and minimize latch
	typedef struct packed {
		logic       mini;
		logic [8:0] c;
	} q_item_t;

	// results of one step, handed from the sequencer to the drain
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [RN_W-1:0]             n_res;
		logic [RN_W-1:0]             n_chr;
		logic [2:0]                  err;
		logic                        ended;
	} batch_t;

	typedef struct packed {
		logic [LA_SLOTS-1:0][8:0] d;
		logic [LA_CW-1:0]         cnt;
	} la_t;

	function automatic logic [8:0] ch(input logic [7:0] c);
		return {1'b0, c};
	endfunction

	function automatic logic is_word(input logic [8:0] c);
		return (c >= ch("a") && c <= ch("z")) || (c >= ch("0") && c <= ch("9")) ||
			(c >= ch("A") && c <= ch("Z")) || c == ch("_") || c == ch("$") ||
			c == ch("\\") || (c > 9'd126 && c < EOFV);
	endfunction

	function automatic logic is_ctl(input logic [8:0] c);
		return (c <= 9'd10) || (c == EOFV);
	endfunction

	function automatic logic rx_lead(input logic [8:0] a);
		return a == ch("(") || a == ch(",") || a == ch("=") || a == ch(":") ||
			a == ch("[") || a == ch("!") || a == ch("&") || a == ch("|") || a == ch("?");
	endfunction

	function automatic logic [1:0] choose(input logic [8:0] a, input logic [8:0] b);
		logic [1:0] r;
		r = CMD_EMIT;
		if (a == ch(" ")) begin
			r = (is_word(b) || b == ch("@")) ? CMD_EMIT : CMD_DEL_A;
		end else if (a == ch("\n")) begin
			if (b == ch("{") || b == ch("[") || b == ch("(") || b == ch("+") || b == ch("-"))
				r = CMD_EMIT;
			else if (b == ch(" "))
				r = CMD_DEL_B;
			else
				r = is_word(b) ? CMD_EMIT : CMD_DEL_A;
		end else if (b == ch(" ")) begin
			r = is_word(a) ? CMD_EMIT : CMD_DEL_B;
		end else if (b == ch("\n")) begin
			if (a == ch("}") || a == ch("]") || a == ch(")") || a == ch("+") || a == ch("-") ||
				a == ch("\"") || a == ch("'") || a == ch("/") || is_word(a))
				r = CMD_EMIT;
			else
				r = CMD_DEL_B;
		end
		return r;
	endfunction

	function automatic la_t la_take1(input la_t l);
		la_t r;
		r = l;
		for (int i = 0; i < LA_SLOTS - 1; i++) r.d[i] = l.d[i + 1];
		if (l.cnt != '0) r.cnt = l.cnt - 1'b1;
		return r;
	endfunction

endpackage

/* rtl/javascript_minifier_stream.sv */
// Streaming JavaScript minifier: top level with configuration registers.
//
// Source bytes arrive one per item transaction, with end_of_input marking the end of the
// file; minified bytes leave as result transactions, several or none per item, with last
// on the final result belonging to an item and stream_done once the file is flushed or an
// unterminated construct has raised error_code. Items first land in a two-entry queue, so
// item_ready stays high while that queue has room; the lexer then runs one action per cycle
// (one stripping pass, window step or literal byte), so an item occupies it while it is loaded,
// for each action plus one more action in which it finds itself short of input, and while it
// hands its results over; there are more actions when held-back lookahead bytes are worked
// off in one step. A step's results wait in a drain register and go out one per cycle while
// result_ready is high, as the lexer carries on with the next item. minimize_on is sampled
// with the first item after reset and holds until reset; the two strip switches act as
// written. Configuration writes are always accepted (cfg_ready is tied high); indexes
// outside the three registers are ignored. After the stream has ended, further items are
// accepted and give no result.
module javascript_minifier_stream import jsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic      cfg_data
);
	logic    strip_comments_q, strip_debug_q, minimize_on_q;
	logic    q_valid, q_pop;
	q_item_t q_item;
	logic    b_valid, b_ready;
	batch_t  b_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_comments_q <= 1'b0;
			strip_debug_q <= 1'b0;
			minimize_on_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STRIP_COMMENTS: strip_comments_q <= cfg_data;
				CFG_STRIP_DEBUG:    strip_debug_q <= cfg_data;
				CFG_MINIMIZE_ON:    minimize_on_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: filter and queue
	jsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.minimize_on(minimize_on_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	// back: lexer sequencer
	jsm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.strip_comments(strip_comments_q),
		.strip_debug   (strip_debug_q),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item),
		.b_valid       (b_valid),
		.b_ready       (b_ready),
		.b_data        (b_data)
	);

	// result register and sender
	jsm_drain u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.b_valid     (b_valid),
		.b_ready     (b_ready),
		.b_data      (b_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

/* rtl/jsm_front.sv */
// Input side: character filter, minimize latch and a two-entry item queue.
module jsm_front import jsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     minimize_on,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     q_valid,
	input  logic     q_pop,
	output q_item_t  q_item
);
	localparam int QD = 2;
	localparam int QW = $clog2(QD);

	q_item_t        fifo_q [QD];
	logic [QW-1:0]  wr_q, rd_q;
	logic [QW:0]    cnt_q;
	logic           mini_set_q, mini_q;
	logic           mini_eff, push;
	logic [7:0]     c;
	q_item_t        entry;

	assign mini_eff = mini_set_q ? mini_q : minimize_on;
	assign item_ready = (cnt_q != (QW + 1)'(QD));
	assign push = item_valid && item_ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = fifo_q[rd_q];

	// control bytes become spaces, CR becomes LF, under minimization
	always_comb begin
		c = item.in_char;
		if (mini_eff && !((c >= 8'd32 && c != 8'd127) || c == 8'd10))
			c = (c == 8'd13) ? 8'd10 : 8'd32;
		entry.mini = mini_eff;
		entry.c = item.end_of_input ? EOFV : {1'b0, c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			mini_set_q <= 1'b0;
			mini_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
				if (!mini_set_q) begin
					mini_set_q <= 1'b1;
					mini_q <= minimize_on;
				end
			end
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QW + 1)'(push) - (QW + 1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= entry;
	end

endmodule

/* rtl/jsm_back.sv */
// Lexer sequencer: lookahead, comment stripping and the minimizing window.
module jsm_back import jsm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    strip_comments,
	input  logic    strip_debug,
	input  logic    q_valid,
	output logic    q_pop,
	input  q_item_t q_item,
	output logic    b_valid,
	input  logic    b_ready,
	output batch_t  b_data
);
	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_RUN = 2'd1;
	localparam logic [1:0] SQ_HAND = 2'd2;

	localparam logic [3:0] LM_BOOT = 4'd0;
	localparam logic [3:0] LM_PLAIN = 4'd1;
	localparam logic [3:0] LM_READB = 4'd2;
	localparam logic [3:0] LM_STR = 4'd3;
	localparam logic [3:0] LM_RX = 4'd4;
	localparam logic [3:0] LM_RX_END = 4'd5;
	localparam logic [3:0] LM_AFTER = 4'd6;
	localparam logic [3:0] LM_CC_AT = 4'd7;
	localparam logic [3:0] LM_CC_B = 4'd8;
	localparam logic [3:0] LM_CC_SLASH = 4'd9;
	localparam logic [3:0] LM_CC_END = 4'd10;
	localparam logic [3:0] LM_DONE = 4'd11;

	localparam logic [1:0] SM_IDLE = 2'd0;
	localparam logic [1:0] SM_LINE = 2'd1;
	localparam logic [1:0] SM_BLOCK = 2'd2;

	localparam logic [1:0] PL_NEED = 2'd0;
	localparam logic [1:0] PL_GOT = 2'd1;
	localparam logic [1:0] PL_ERR = 2'd2;
	localparam logic [1:0] PL_CONT = 2'd3;

	logic [1:0]      seq_q, n_seq;
	logic [8:0]      ca_q, cb_q, n_ca, n_cb;
	la_t             la_q, n_la;
	logic [3:0]      mode_q, n_mode;
	logic            bwd_q, esc_q, prim_q, cond_q, eof_q, mini_q, over_q;
	logic            n_bwd, n_esc, n_prim, n_cond, n_eof, n_mini, n_over;
	logic [2:0]      err_q, n_err;
	logic [1:0]      sm_q, n_sm, cmd_q, n_cmd;
	logic [7:0]      buf_q [MAX_RESULTS];
	logic [7:0]      n_buf [MAX_RESULTS];
	logic [RN_W-1:0] nem_q, n_nem;

	logic [7:0]      em [3];
	logic [1:0]      ne;
	logic            stop, do_finish, do_start, do_shift, poll_use, got, sc;
	logic [1:0]      k_cmd;
	logic [2:0]      fail_code;
	logic [8:0]      p0, p1, p2, pl_c;
	logic            av1, av2, av3;
	logic [1:0]      pl_st, pl_sm;
	la_t             pl_la;
	logic [RN_W:0]   widx;

	assign p0 = (la_q.cnt > LA_CW'(0)) ? la_q.d[0] : EOFV;
	assign p1 = (la_q.cnt > LA_CW'(1)) ? la_q.d[1] : EOFV;
	assign p2 = (la_q.cnt > LA_CW'(2)) ? la_q.d[2] : EOFV;
	assign av1 = eof_q || (la_q.cnt >= LA_CW'(1));
	assign av2 = eof_q || (la_q.cnt >= LA_CW'(2));
	assign av3 = eof_q || (la_q.cnt >= LA_CW'(3));
	assign sc = strip_comments || mini_q;

	// one pass of the stripping stage
	always_comb begin
		pl_st = PL_NEED;
		pl_c = EOFV;
		pl_la = la_q;
		pl_sm = sm_q;
		case (sm_q)
			SM_LINE: begin
				if (av1) begin
					pl_la = la_take1(la_q);
					pl_c = p0;
					if (is_ctl(p0)) begin
						pl_sm = SM_IDLE;
						pl_st = PL_GOT;
					end else begin
						pl_st = PL_CONT;
					end
				end
			end
			SM_BLOCK: begin
				if (av1) begin
					if (p0 == EOFV) begin
						pl_st = PL_ERR;
					end else if (p0 == ch("*")) begin
						if (av2) begin
							if (p1 == ch("/")) begin
								pl_la = la_take1(la_take1(la_q));
								pl_sm = SM_IDLE;
								pl_c = ch(" ");
								pl_st = PL_GOT;
							end else begin
								pl_la = la_take1(la_q);
								pl_st = PL_CONT;
							end
						end
					end else begin
						pl_la = la_take1(la_q);
						pl_st = PL_CONT;
					end
				end
			end
			default: begin
				if (av1) begin
					pl_la = la_take1(la_q);
					pl_c = p0;
					pl_st = PL_GOT;
					if (sc && p0 == ch("/")) begin
						if (!av2) begin
							pl_st = PL_NEED;
						end else if (p1 == ch("/")) begin
							pl_sm = SM_LINE;
							pl_st = PL_CONT;
						end else if (p1 == ch("*")) begin
							if (!av3) begin
								pl_st = PL_NEED;
							end else if (p2 != ch("@")) begin
								pl_la = la_take1(la_take1(la_q));
								pl_sm = SM_BLOCK;
								pl_st = PL_CONT;
							end
						end
					end else if (strip_debug && p0 == ch(";")) begin
						if (!av2) begin
							pl_st = PL_NEED;
						end else if (p1 == ch(";")) begin
							if (!av3) begin
								pl_st = PL_NEED;
							end else if (p2 == ch(";")) begin
								pl_sm = SM_LINE;
								pl_st = PL_CONT;
							end
						end
					end
				end
			end
		endcase
	end

	assign got = (pl_st == PL_GOT);

	always_comb begin
		n_seq = seq_q;
		n_ca = ca_q;
		n_cb = cb_q;
		n_la = la_q;
		n_mode = mode_q;
		n_bwd = bwd_q;
		n_esc = esc_q;
		n_prim = prim_q;
		n_cond = cond_q;
		n_eof = eof_q;
		n_mini = mini_q;
		n_over = over_q;
		n_err = err_q;
		n_sm = sm_q;
		n_cmd = cmd_q;
		n_nem = nem_q;
		n_buf = buf_q;
		for (int i = 0; i < 3; i++) em[i] = 8'd0;
		ne = 2'd0;
		stop = 1'b0;
		do_finish = 1'b0;
		do_start = 1'b0;
		do_shift = 1'b0;
		poll_use = 1'b0;
		k_cmd = CMD_EMIT;
		fail_code = ERR_NONE;
		widx = '0;
		q_pop = 1'b0;
		b_valid = 1'b0;

		case (seq_q)
			SQ_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					// once the stream is over, items are taken and dropped
					if (!over_q) begin
						if (mode_q == LM_BOOT) n_mini = q_item.mini;
						if (!eof_q) begin
							if (q_item.c == EOFV) begin
								n_eof = 1'b1;
							end else begin
								for (int i = 0; i < LA_SLOTS; i++)
									if (la_q.cnt == LA_CW'(i)) n_la.d[i] = q_item.c;
								if (la_q.cnt < LA_CW'(LA_SLOTS)) n_la.cnt = la_q.cnt + 1'b1;
							end
						end
						n_nem = '0;
						n_seq = SQ_RUN;
					end
				end
			end
			SQ_RUN: begin
				case (mode_q)
					LM_BOOT: begin
						if (mini_q) begin
							n_ca = ch("\n");
							n_bwd = 1'b0;
							n_prim = 1'b1;
							n_cmd = CMD_DEL_B;
							n_mode = LM_READB;
						end else begin
							n_mode = LM_PLAIN;
						end
					end
					LM_PLAIN: begin
						poll_use = 1'b1;
						if (got) begin
							if (pl_c == EOFV) begin
								n_mode = LM_DONE;
								n_over = 1'b1;
								stop = 1'b1;
							end else begin
								em[ne] = pl_c[7:0];
								ne = ne + 2'd1;
							end
						end
					end
					LM_READB: begin
						poll_use = 1'b1;
						if (got) begin
							n_cb = pl_c;
							if (pl_c == ch("/") && rx_lead(ca_q)) begin
								em[ne] = ca_q[7:0];
								ne = ne + 2'd1;
								em[ne] = pl_c[7:0];
								ne = ne + 2'd1;
								n_mode = LM_RX;
							end else begin
								n_mode = LM_AFTER;
							end
						end
					end
					LM_STR, LM_RX: begin
						if (!av1) begin
							stop = 1'b1;
						end else begin
							n_la = la_take1(la_q);
							n_ca = p0;
							if (esc_q) begin
								n_esc = 1'b0;
								if (p0 == EOFV) begin
									fail_code = (mode_q == LM_STR) ? ERR_STRING : ERR_REGEX;
								end else begin
									em[ne] = p0[7:0];
									ne = ne + 2'd1;
								end
							end else if (mode_q == LM_STR && p0 == cb_q) begin
								n_mode = LM_READB;
							end else if (mode_q == LM_RX && p0 == ch("/")) begin
								n_mode = LM_RX_END;
							end else if (mode_q == LM_RX && p0 == ch("\\")) begin
								em[ne] = p0[7:0];
								ne = ne + 2'd1;
								n_esc = 1'b1;
							end else if (is_ctl(p0)) begin
								fail_code = (mode_q == LM_STR) ? ERR_STRING : ERR_REGEX;
							end else begin
								em[ne] = p0[7:0];
								ne = ne + 2'd1;
								if (p0 == ch("\\")) n_esc = 1'b1;
							end
						end
					end
					LM_RX_END: begin
						poll_use = 1'b1;
						if (got) begin
							n_cb = pl_c;
							n_mode = LM_AFTER;
						end
					end
					LM_AFTER: begin
						if (!cond_q) begin
							if (ca_q == ch("/") && cb_q == ch("*") && !av1) begin
								stop = 1'b1;
							end else if (ca_q == ch("/") && cb_q == ch("*") && p0 == ch("@")) begin
								em[0] = 8'h0A;
								em[1] = "/";
								em[2] = "*";
								ne = 2'd3;
								n_mode = LM_CC_AT;
							end else begin
								do_finish = 1'b1;
							end
						end else begin
							if (ca_q == ch("@") && cb_q == ch("*") && !av1) begin
								stop = 1'b1;
							end else if (ca_q == ch("@") && cb_q == ch("*") && p0 == ch("/")) begin
								em[0] = ca_q[7:0];
								em[1] = cb_q[7:0];
								ne = 2'd2;
								n_mode = LM_CC_SLASH;
							end else if (ca_q == EOFV) begin
								fail_code = ERR_COND;
							end else begin
								em[ne] = ca_q[7:0];
								ne = ne + 2'd1;
								do_shift = 1'b1;
							end
						end
					end
					LM_CC_AT, LM_CC_SLASH: begin
						if (!av1) begin
							stop = 1'b1;
						end else begin
							n_la = la_take1(la_q);
							n_ca = p0;
							n_mode = (mode_q == LM_CC_AT) ? LM_CC_B : LM_CC_END;
						end
					end
					LM_CC_B: begin
						poll_use = 1'b1;
						if (got) begin
							n_cb = pl_c;
							n_cond = 1'b1;
							em[ne] = ca_q[7:0];
							ne = ne + 2'd1;
							do_shift = 1'b1;
						end
					end
					LM_CC_END: begin
						poll_use = 1'b1;
						if (got) begin
							n_cb = pl_c;
							n_cond = 1'b0;
							do_finish = 1'b1;
						end
					end
					default: stop = 1'b1;
				endcase

				// window command completes, next one starts
				if (do_finish) begin
					n_bwd = (n_cmd == CMD_DEL_B);
					if (n_prim) begin
						n_prim = 1'b0;
						k_cmd = CMD_DEL_A;
						do_start = 1'b1;
					end else if (n_ca == EOFV) begin
						n_mode = LM_DONE;
						n_over = 1'b1;
						stop = 1'b1;
					end else begin
						k_cmd = choose(n_ca, n_cb);
						do_start = 1'b1;
					end
				end
				if (do_start) begin
					n_cmd = k_cmd;
					if (k_cmd == CMD_EMIT) begin
						em[ne] = n_ca[7:0];
						ne = ne + 2'd1;
						// keep "+ +" and "- -" apart
						if (n_bwd && n_ca == n_cb && (n_ca == ch("+") || n_ca == ch("-"))) begin
							em[ne] = " ";
							ne = ne + 2'd1;
						end
					end
					if (k_cmd == CMD_DEL_B) n_mode = LM_READB;
					else do_shift = 1'b1;
				end
				if (do_shift) begin
					n_ca = n_cb;
					if (n_ca == ch("'") || n_ca == ch("\"")) begin
						em[ne] = n_ca[7:0];
						ne = ne + 2'd1;
						n_mode = LM_STR;
					end else begin
						n_mode = LM_READB;
					end
				end

				if (poll_use) begin
					case (pl_st)
						PL_GOT, PL_CONT: begin
							n_la = pl_la;
							n_sm = pl_sm;
						end
						PL_ERR: fail_code = ERR_COMMENT;
						default: stop = 1'b1;
					endcase
				end
				if (fail_code != ERR_NONE) begin
					n_err = fail_code;
					n_mode = LM_DONE;
					n_over = 1'b1;
					stop = 1'b1;
				end

				// bytes past the eighth of a step are dropped
				for (int i = 0; i < 3; i++) begin
					widx = {1'b0, nem_q} + (RN_W + 1)'(i);
					if (2'(i) < ne && widx < (RN_W + 1)'(MAX_RESULTS))
						n_buf[widx[RI_W-1:0]] = em[i];
				end
				widx = {1'b0, nem_q} + (RN_W + 1)'(ne);
				n_nem = (widx > (RN_W + 1)'(MAX_RESULTS)) ? RN_W'(MAX_RESULTS) : widx[RN_W-1:0];

				if (stop) n_seq = SQ_HAND;
			end
			SQ_HAND: begin
				b_valid = (nem_q != '0) || over_q;
				if (!b_valid || b_ready) n_seq = SQ_IDLE;
			end
			default: n_seq = SQ_IDLE;
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) b_data.bytes[i] = buf_q[i];
		b_data.n_chr = nem_q;
		b_data.n_res = (nem_q == '0) ? RN_W'(1) : nem_q;
		b_data.err = err_q;
		b_data.ended = over_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
			ca_q <= ch("\n");
			cb_q <= '0;
			la_q <= '0;
			mode_q <= LM_BOOT;
			bwd_q <= 1'b0;
			esc_q <= 1'b0;
			prim_q <= 1'b0;
			cond_q <= 1'b0;
			eof_q <= 1'b0;
			mini_q <= 1'b0;
			over_q <= 1'b0;
			err_q <= ERR_NONE;
			sm_q <= SM_IDLE;
			cmd_q <= CMD_DEL_B;
			nem_q <= '0;
		end else begin
			seq_q <= n_seq;
			ca_q <= n_ca;
			cb_q <= n_cb;
			la_q <= n_la;
			mode_q <= n_mode;
			bwd_q <= n_bwd;
			esc_q <= n_esc;
			prim_q <= n_prim;
			cond_q <= n_cond;
			eof_q <= n_eof;
			mini_q <= n_mini;
			over_q <= n_over;
			err_q <= n_err;
			sm_q <= n_sm;
			cmd_q <= n_cmd;
			nem_q <= n_nem;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= n_buf;
	end

	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nem_q <= RN_W'(MAX_RESULTS))
		else $error("step result count beyond buffer");
	a_over_done: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> mode_q == LM_DONE)
		else $error("stream over but lexer still active");
	a_err_over: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> over_q)
		else $error("error latched without stopping");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != SQ_IDLE) |-> !q_pop)
		else $error("item taken while a step is in progress");

endmodule

/* rtl/jsm_drain.sv */
// Output side: holds one step's results and sends them one per transaction.
module jsm_drain import jsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      b_valid,
	output logic      b_ready,
	input  batch_t    b_data,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);
	batch_t          bat_q;
	logic            dv_q;
	logic [RI_W-1:0] idx_q;
	logic            has, is_last;

	assign b_ready = !dv_q;
	assign result_valid = dv_q;
	assign has = ({1'b0, idx_q} < bat_q.n_chr);
	assign is_last = ({1'b0, idx_q} == (bat_q.n_res - 1'b1));

	always_comb begin
		result.out_char = has ? bat_q.bytes[idx_q] : 8'd0;
		result.has_char = has;
		result.error_code = bat_q.err;
		result.last = is_last;
		result.stream_done = bat_q.ended && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
			idx_q <= '0;
		end else if (dv_q) begin
			if (result_ready) begin
				if (is_last) dv_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end else if (b_valid) begin
			dv_q <= 1'b1;
			idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (!dv_q && b_valid) bat_q <= b_data;
	end

endmodule
